// ===== hw/rtl/rmo_pkg.sv =====
// rmo_pkg: widths, types and constants of the rotation matrix orthonormalizer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package rmo_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int NROW      = 3;
  localparam int NCOMP     = 3 * NROW;

  localparam int PR_W   = 2 * IN_W;        // a*b product
  localparam int C_W    = PR_W + 1;        // cross product component
  localparam int CA_W   = C_W + IN_W;      // c*a product
  localparam int BP_W   = CA_W;            // rebuilt row component
  localparam int MAG_W  = BP_W - 1;        // magnitude of any row component
  localparam int HALF_W = MAG_W / 2;
  localparam int SQ_W   = 2 * MAG_W;       // squared magnitude
  localparam int S_W    = SQ_W + 2;        // sum of three squares
  localparam int Q_W    = FRAC_BITS + 1;   // unit magnitude, up to 1.0
  localparam int R_W    = S_W + 2 * FRAC_BITS + 8;

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [OUT_W-1:0] out_t;
  typedef logic signed [R_W-1:0]   res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmo_if.sv =====
// rmo_in_if / rmo_out_if: valid/ready channels for input and result words
// depends on rmo_pkg
`default_nettype none

interface rmo_in_if
  import rmo_pkg::*;
();
  logic valid;
  logic ready;
  in_t  row_a_x;
  in_t  row_a_y;
  in_t  row_a_z;
  in_t  row_b_x;
  in_t  row_b_y;
  in_t  row_b_z;

  modport source (output valid, row_a_x, row_a_y, row_a_z, row_b_x, row_b_y, row_b_z,
                  input ready);
  modport sink (input valid, row_a_x, row_a_y, row_a_z, row_b_x, row_b_y, row_b_z,
                output ready);
endinterface

interface rmo_out_if
  import rmo_pkg::*;
();
  logic valid;
  logic ready;
  out_t unit_a_x;
  out_t unit_a_y;
  out_t unit_a_z;
  out_t unit_b_x;
  out_t unit_b_y;
  out_t unit_b_z;
  out_t unit_c_x;
  out_t unit_c_y;
  out_t unit_c_z;
  logic degenerate;

  modport source (output valid, unit_a_x, unit_a_y, unit_a_z, unit_b_x, unit_b_y, unit_b_z,
                  unit_c_x, unit_c_y, unit_c_z, degenerate, input ready);
  modport sink (input valid, unit_a_x, unit_a_y, unit_a_z, unit_b_x, unit_b_y, unit_b_z,
                unit_c_x, unit_c_y, unit_c_z, degenerate, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rotation_matrix_orthonormalize.sv =====
// rotation_matrix_orthonormalize: cross product orthonormalization of a 3x3 matrix
// depends on rmo_pkg and the rmo_in_if / rmo_out_if channel interfaces
//
//   channel  dir  word
//   in_ch    in   rows a and b, six Q1.14 components
//   out_ch   out  unit rows a, b', c and degenerate flag
//
// one word per cycle while no stall holds the pipeline; each result comes from
// the bit-per-stage rounding search, one stage per result bit
// synchronous active-low reset clears the valid bits, among them those of the output and skid registers
// a stall at the output fills the skid register, then freezes the whole pipeline
`default_nettype none

module rotation_matrix_orthonormalize
  import rmo_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmo_in_if.sink     in_ch,
  rmo_out_if.source  out_ch
);

  logic en;
  logic skid_v_r;
  logic out_v_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // stage 1: a*b products
  logic              v1_r, az1_r;
  logic signed [PR_W-1:0] p1_r [6];
  logic signed [IN_W-1:0] a1_r [NROW];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= in_ch.row_a_y * in_ch.row_b_z;
      p1_r[1] <= in_ch.row_a_z * in_ch.row_b_y;
      p1_r[2] <= in_ch.row_a_z * in_ch.row_b_x;
      p1_r[3] <= in_ch.row_a_x * in_ch.row_b_z;
      p1_r[4] <= in_ch.row_a_x * in_ch.row_b_y;
      p1_r[5] <= in_ch.row_a_y * in_ch.row_b_x;
      a1_r[0] <= in_ch.row_a_x;
      a1_r[1] <= in_ch.row_a_y;
      a1_r[2] <= in_ch.row_a_z;
      az1_r   <= (in_ch.row_a_x == '0) && (in_ch.row_a_y == '0) && (in_ch.row_a_z == '0);
    end
  end

  // stage 2: c = a x b
  logic              v2_r, az2_r;
  logic signed [C_W-1:0]  c2_r [NROW];
  logic signed [IN_W-1:0] a2_r [NROW];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NROW; i++) begin
        c2_r[i] <= C_W'(p1_r[2*i]) - C_W'(p1_r[2*i+1]);
        a2_r[i] <= a1_r[i];
      end
      az2_r <= az1_r;
    end
  end

  // stage 3: c*a products
  logic              v3_r, az3_r, cz3_r;
  logic signed [CA_W-1:0] q3_r [6];
  logic signed [C_W-1:0]  c3_r [NROW];
  logic signed [IN_W-1:0] a3_r [NROW];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3_r[0] <= c2_r[1] * a2_r[2];
      q3_r[1] <= c2_r[2] * a2_r[1];
      q3_r[2] <= c2_r[2] * a2_r[0];
      q3_r[3] <= c2_r[0] * a2_r[2];
      q3_r[4] <= c2_r[0] * a2_r[1];
      q3_r[5] <= c2_r[1] * a2_r[0];
      for (int i = 0; i < NROW; i++) begin
        c3_r[i] <= c2_r[i];
        a3_r[i] <= a2_r[i];
      end
      az3_r <= az2_r;
      cz3_r <= (c2_r[0] == '0) && (c2_r[1] == '0) && (c2_r[2] == '0);
    end
  end

  // stage 4: b' = c x a
  logic              v4_r, az4_r, cz4_r;
  logic signed [BP_W-1:0] vec4_r [NCOMP];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NROW; i++) begin
        vec4_r[i]          <= BP_W'(a3_r[i]);
        vec4_r[NROW + i]   <= q3_r[2*i] - q3_r[2*i+1];
        vec4_r[2*NROW + i] <= BP_W'(c3_r[i]);
      end
      az4_r <= az3_r;
      cz4_r <= cz3_r;
    end
  end

  // stage 5: magnitudes and signs
  logic              v5_r, az5_r, cz5_r;
  logic [MAG_W-1:0]  mag5_r [NCOMP];
  logic [NCOMP-1:0]  sg5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NCOMP; j++) begin
        mag5_r[j] <= MAG_W'(vec4_r[j][BP_W-1] ? -vec4_r[j] : vec4_r[j]);
        sg5_r[j]  <= vec4_r[j][BP_W-1];
      end
      az5_r <= az4_r;
      cz5_r <= cz4_r;
    end
  end

  // stage 6: partial products of the squares, split in halves
  logic              v6_r, az6_r, cz6_r;
  logic [2*HALF_W-1:0] hh6_r [NCOMP];
  logic [2*HALF_W-1:0] hl6_r [NCOMP];
  logic [2*HALF_W-1:0] ll6_r [NCOMP];
  logic [NCOMP-1:0]  sg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NCOMP; j++) begin
        hh6_r[j] <= mag5_r[j][MAG_W-1:HALF_W] * mag5_r[j][MAG_W-1:HALF_W];
        hl6_r[j] <= mag5_r[j][MAG_W-1:HALF_W] * mag5_r[j][HALF_W-1:0];
        ll6_r[j] <= mag5_r[j][HALF_W-1:0] * mag5_r[j][HALF_W-1:0];
      end
      sg6_r <= sg5_r;
      az6_r <= az5_r;
      cz6_r <= cz5_r;
    end
  end

  // stage 7: component squares
  logic              v7_r, az7_r, cz7_r;
  logic [SQ_W-1:0]   m2_7_r [NCOMP];
  logic [NCOMP-1:0]  sg7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NCOMP; j++) begin
        m2_7_r[j] <= (SQ_W'(hh6_r[j]) << (2*HALF_W)) + (SQ_W'(hl6_r[j]) << (HALF_W+1))
                   + SQ_W'(ll6_r[j]);
      end
      sg7_r <= sg6_r;
      az7_r <= az6_r;
      cz7_r <= cz6_r;
    end
  end

  // stage 8: squared row lengths
  logic              v8_r, az8_r, cz8_r;
  logic [SQ_W-1:0]   m2_8_r [NCOMP];
  logic [S_W-1:0]    s8_r [NROW];
  logic [NCOMP-1:0]  sg8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NROW; r++) begin
        s8_r[r] <= S_W'(m2_7_r[3*r]) + S_W'(m2_7_r[3*r+1]) + S_W'(m2_7_r[3*r+2]);
      end
      for (int j = 0; j < NCOMP; j++) m2_8_r[j] <= m2_7_r[j];
      sg8_r <= sg7_r;
      az8_r <= az7_r;
      cz8_r <= cz7_r;
    end
  end

  // search state per component: rem = T - u*u*S and prd = u*S with u = 2q-1,
  // T = 4*m*m*2^(2F); starting point q = 0, u = -1
  logic             sv_r  [Q_W+1];
  logic             saz_r [Q_W+1];
  logic             scz_r [Q_W+1];
  res_t             sr_r  [Q_W+1][NCOMP];
  res_t             sp_r  [Q_W+1][NCOMP];
  logic [S_W-1:0]   ss_r  [Q_W+1][NROW];
  logic [Q_W-1:0]   sq_r  [Q_W+1][NCOMP];
  logic [NCOMP-1:0] scap_r [Q_W+1];
  logic [NCOMP-1:0] ssg_r [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (en) sv_r[0] <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NCOMP; j++) begin
        sr_r[0][j] <= signed'(R_W'(m2_8_r[j]) << (2*FRAC_BITS + 2))
                    - signed'(R_W'(s8_r[j/3]));
        sp_r[0][j] <= -signed'(R_W'(s8_r[j/3]));
        sq_r[0][j] <= '0;
      end
      for (int r = 0; r < NROW; r++) ss_r[0][r] <= s8_r[r];
      scap_r[0] <= '0;
      ssg_r[0]  <= sg8_r;
      saz_r[0]  <= az8_r;
      scz_r[0]  <= cz8_r;
    end
  end

  // one result bit per stage, most significant first
  for (genvar i = 0; i < Q_W; i++) begin : g_stg
    localparam int K = FRAC_BITS - i;

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[i+1] <= 1'b0;
      else if (en) sv_r[i+1] <= sv_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int r = 0; r < NROW; r++) ss_r[i+1][r] <= ss_r[i][r];
        ssg_r[i+1] <= ssg_r[i];
        saz_r[i+1] <= saz_r[i];
        scz_r[i+1] <= scz_r[i];
      end
    end

    for (genvar j = 0; j < NCOMP; j++) begin : g_cmp
      res_t s_ext, dlt, rc;
      logic take;

      assign s_ext = signed'(R_W'(ss_r[i][j/3]));
      // growth of u*u*S when q gains 2^K
      assign dlt   = (sp_r[i][j] + (s_ext <<< K)) <<< (K + 2);
      assign rc    = sr_r[i][j] - dlt;
      // once q reaches 1.0 no lower bit may be added
      assign take  = !scap_r[i][j] && !rc[R_W-1];

      always_ff @(posedge clk) begin
        if (en) begin
          sr_r[i+1][j]   <= take ? rc : sr_r[i][j];
          sp_r[i+1][j]   <= take ? sp_r[i][j] + (s_ext <<< (K + 1)) : sp_r[i][j];
          sq_r[i+1][j]   <= take ? sq_r[i][j] | (Q_W'(1) << K) : sq_r[i][j];
          scap_r[i+1][j] <= scap_r[i][j] | (take && (K == FRAC_BITS));
        end
      end
    end
  end

  // sign, zero rows, fit to the output width
  logic [OUT_W-1:0] fin [NCOMP];

  for (genvar j = 0; j < NCOMP; j++) begin : g_fin
    logic signed [Q_W:0] qs;
    logic zr;
    assign qs  = ssg_r[Q_W][j] ? -signed'({1'b0, sq_r[Q_W][j]})
                                :  signed'({1'b0, sq_r[Q_W][j]});
    assign zr  = (j < NROW) ? saz_r[Q_W] : scz_r[Q_W];
    assign fin[j] = zr ? '0 : OUT_W'(qs);
  end

  // output register and skid register
  logic [OUT_W-1:0] out_r  [NCOMP];
  logic [OUT_W-1:0] skid_r [NCOMP];
  logic             out_dg_r, skid_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_ch.ready || !out_v_r) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= sv_r[Q_W];
        end
      end else if (sv_r[Q_W] && en) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_dg_r <= skid_dg_r;
      end else begin
        out_r    <= fin;
        out_dg_r <= scz_r[Q_W];
      end
    end else if (en) begin
      skid_r    <= fin;
      skid_dg_r <= scz_r[Q_W];
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.unit_a_x   = signed'(out_r[0]);
  assign out_ch.unit_a_y   = signed'(out_r[1]);
  assign out_ch.unit_a_z   = signed'(out_r[2]);
  assign out_ch.unit_b_x   = signed'(out_r[3]);
  assign out_ch.unit_b_y   = signed'(out_r[4]);
  assign out_ch.unit_b_z   = signed'(out_r[5]);
  assign out_ch.unit_c_x   = signed'(out_r[6]);
  assign out_ch.unit_c_y   = signed'(out_r[7]);
  assign out_ch.unit_c_z   = signed'(out_r[8]);
  assign out_ch.degenerate = out_dg_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid register filled without an output stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_dg_r) |->
      (out_r[3] == '0 && out_r[4] == '0 && out_r[5] == '0 &&
       out_r[6] == '0 && out_r[7] == '0 && out_r[8] == '0))
    else $error("degenerate word carries nonzero b or c rows");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_dg_r) |->
      ((out_r[0] != '0 || out_r[1] != '0 || out_r[2] != '0) &&
       (out_r[6] != '0 || out_r[7] != '0 || out_r[8] != '0)))
    else $error("normalized row came out all zero");
`endif

endmodule

`default_nettype wire
